// ===== design/ofe_pkg.sv =====
package ofe_pkg;

    // Default build sizes
    localparam int MAX_FRAME_DEF   = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    // Configuration register map
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 7;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_LEN = 8'd1;

    // Register field widths and reset values
    localparam int FRAME_LEN_W   = 7;
    localparam int OVERLAP_LEN_W = 6;
    localparam int POS_W         = 6;
    localparam logic [FRAME_LEN_W-1:0]   FRAME_LEN_RST   = 7'd64;
    localparam logic [OVERLAP_LEN_W-1:0] OVERLAP_LEN_RST = 6'd0;

    // Sequencer states
    typedef enum logic [0:0] {
        ST_COLLECT,
        ST_READ
    } t_state;

endpackage

// ===== design/overlapping_frame_extractor.sv =====
// Overlapping frame extractor. Each input transaction carries one signed sample that is
// written into a ring of the last MAX_FRAME samples. Once frame_len samples have arrived
// the first frame is sent, oldest sample first; after that a frame of the latest frame_len
// samples is sent each time frame_len - overlap_len new samples have arrived. Every output
// transaction carries one sample and its position in the frame; tlast marks the final one.
// An input that completes no frame does not hold off the next input. An input that
// completes a frame starts a read-back of the frame through the single read port of the
// sample ring, one sample per cycle while the output does not stall, and the input is not
// ready until the last read is issued. The ring needs no clearing pass: only samples
// written since the last reset or register write are ever read. Write registers
// (0: frame_len, 1: overlap_len) only while the block is idle; a write to either one
// restarts the sample count. frame_len of zero acts as 1, above MAX_FRAME as MAX_FRAME,
// and overlap_len is clamped below the frame length.
module overlapping_frame_extractor
    import ofe_pkg::*;
#(
    parameter int MAX_FRAME   = MAX_FRAME_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Configuration write channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]                   i_cfg_index,
    input  logic [CFG_DAT_W-1:0]                   i_cfg_data,
    // Sample input
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata: sample (SAMPLE_BITS, signed), zero fill
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
    // Frame output
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // tdata: frame_sample (SAMPLE_BITS, signed), position (6), zero fill
    output logic [((SAMPLE_BITS+POS_W+7)/8)*8-1:0] m_axis_tdata,
    output logic                                   m_axis_tlast
);

    localparam int AW    = $clog2(MAX_FRAME);
    localparam int FW    = $clog2(MAX_FRAME + 1);
    localparam int SW    = AW + 1;
    localparam int OUT_W = ((SAMPLE_BITS + POS_W + 7) / 8) * 8;

    // Configuration registers
    logic [FRAME_LEN_W-1:0]   r_frame_len;
    logic [OVERLAP_LEN_W-1:0] r_overlap_len;

    // Ring and frame counters
    logic [AW-1:0] r_slot;
    logic [AW-1:0] n_slot;
    logic [FW-1:0] r_fresh;
    logic [FW-1:0] n_fresh;
    logic          r_first_done;

    // Read sequencer
    t_state        r_state;
    t_state        n_state;
    logic [FW-1:0] r_left;
    logic [AW-1:0] r_k;
    logic [AW-1:0] r_rd_addr;
    logic          r_rd_valid;
    logic [POS_W-1:0] r_rd_pos;
    logic          r_rd_last;

    // Output register
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_sample;
    logic [POS_W-1:0]       r_out_pos;
    logic                   r_out_last;

    logic                   cfg_fire;
    logic                   cfg_known;
    logic                   in_fire;
    logic                   in_ready;
    logic                   emit;
    logic                   issue;
    logic                   load_out;
    logic [FW-1:0]          f_eff;
    logic [FW-1:0]          o_eff;
    logic [FW-1:0]          need;
    logic [SW-1:0]          start_sum;
    logic [AW-1:0]          start_addr;
    logic [AW-1:0]          rd_addr_next;
    logic [SAMPLE_BITS-1:0] rd_data;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign cfg_known   = (i_cfg_index == REG_FRAME_LEN) || (i_cfg_index == REG_OVERLAP_LEN);
    assign in_fire     = s_axis_tvalid && s_axis_tready;

    // Effective frame length and overlap
    always_comb begin
        if (r_frame_len == '0) begin
            f_eff = FW'(1);
        end else if (r_frame_len > MAX_FRAME) begin
            f_eff = FW'(MAX_FRAME);
        end else begin
            f_eff = FW'(r_frame_len);
        end
        if (r_overlap_len >= f_eff) begin
            o_eff = f_eff - FW'(1);
        end else begin
            o_eff = FW'(r_overlap_len);
        end
        need = r_first_done ? (f_eff - o_eff) : f_eff;
    end

    // Advance write slot and saturating sample count
    assign n_slot  = (r_slot == AW'(MAX_FRAME - 1)) ? '0 : r_slot + AW'(1);
    assign n_fresh = (r_fresh < FW'(MAX_FRAME)) ? r_fresh + FW'(1) : r_fresh;
    assign emit    = (n_fresh >= need);

    // Oldest slot of the latest f_eff samples
    always_comb begin
        start_sum = SW'(n_slot) + SW'(MAX_FRAME) - SW'(f_eff);
        if (start_sum >= SW'(MAX_FRAME)) begin
            start_sum = start_sum - SW'(MAX_FRAME);
        end
        start_addr = start_sum[AW-1:0];
    end

    // Read issue and output load
    assign load_out     = r_rd_valid && (!r_out_valid || m_axis_tready);
    assign issue        = (r_left != '0) && (!r_rd_valid || load_out);
    assign rd_addr_next = (r_rd_addr == AW'(MAX_FRAME - 1)) ? '0 : r_rd_addr + AW'(1);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and input ready
    always_comb begin
        n_state  = r_state;
        in_ready = 1'b0;
        case (r_state)
            ST_COLLECT: begin
                in_ready = 1'b1;
                if (s_axis_tvalid && emit) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (issue && (r_left == FW'(1))) begin
                    n_state = ST_COLLECT;
                end
            end
            default: begin
                n_state = ST_COLLECT;
            end
        endcase
    end

    assign s_axis_tready = in_ready;

    // Configuration registers, ring counters and read sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_len   <= FRAME_LEN_RST;
            r_overlap_len <= OVERLAP_LEN_RST;
            r_slot        <= '0;
            r_fresh       <= '0;
            r_first_done  <= 1'b0;
            r_left        <= '0;
            r_k           <= '0;
            r_rd_addr     <= '0;
            r_rd_valid    <= 1'b0;
        end else begin
            if (cfg_fire && cfg_known) begin
                if (i_cfg_index == REG_FRAME_LEN) begin
                    r_frame_len <= i_cfg_data[FRAME_LEN_W-1:0];
                end else begin
                    r_overlap_len <= i_cfg_data[OVERLAP_LEN_W-1:0];
                end
                r_slot       <= '0;
                r_fresh      <= '0;
                r_first_done <= 1'b0;
            end else if (in_fire) begin
                r_slot <= n_slot;
                if (emit) begin
                    r_fresh      <= '0;
                    r_first_done <= 1'b1;
                    r_left       <= f_eff;
                    r_k          <= '0;
                    r_rd_addr    <= start_addr;
                end else begin
                    r_fresh <= n_fresh;
                end
            end
            if (issue) begin
                r_left     <= r_left - FW'(1);
                r_k        <= r_k + AW'(1);
                r_rd_addr  <= rd_addr_next;
                r_rd_valid <= 1'b1;
            end else if (load_out) begin
                r_rd_valid <= 1'b0;
            end
        end
    end

    // Side data that travels with each read
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_pos  <= POS_W'(r_k);
            r_rd_last <= (r_left == FW'(1));
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_sample <= rd_data;
            r_out_pos    <= r_rd_pos;
            r_out_last   <= r_rd_last;
        end
    end

    ofe_ring #(
        .DEPTH (MAX_FRAME),
        .WIDTH (SAMPLE_BITS)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (in_fire),
        .i_wr_addr (r_slot),
        .i_wr_data (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_rd_en   (issue),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (rd_data)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_out_pos, r_out_sample});
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTH
    // Reads outstanding only while the sequencer is reading
    a_left_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left != '0) |-> (r_state == ST_READ))
        else $error("reads pending outside read state");

    // The last sample of a frame sits at position frame length minus one
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_out_pos == POS_W'(f_eff - FW'(1))))
        else $error("frame end at wrong position");

    // Sample count never passes the ring depth
    a_fresh_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh <= FW'(MAX_FRAME))
        else $error("sample count out of range");

    // A frame start loads the full frame length into the read counter
    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && emit && !cfg_fire) |=> (r_left == $past(f_eff)))
        else $error("frame read not started");
`endif

endmodule

// ===== design/ofe_ring.sv =====
module ofe_ring
    import ofe_pkg::*;
#(
    parameter int DEPTH = MAX_FRAME_DEF,
    parameter int WIDTH = SAMPLE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, holds its data while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
